// File: design/fdlt_pkg.sv
`default_nettype none
package fdlt_pkg;

	localparam int DEPTH       = 4096;
	localparam int ADDR_BITS   = $clog2(DEPTH);
	localparam int LEN_BITS    = ADDR_BITS + 1;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int DELAY_BITS  = 28;
	localparam int INT_BITS    = DELAY_BITS - FRAC_BITS;
	localparam int POS_BITS    = 12;
	localparam int MODE_BITS   = 2;
	localparam int CFG_DATA_BITS = LEN_BITS;

	// coefficient divider and modulo unit widths
	localparam int NUM_BITS     = FRAC_BITS + SAMPLE_BITS - 1;
	localparam int DEN_BITS     = FRAC_BITS + 2;
	localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
	localparam int MOD_CNT_BITS = $clog2(LEN_BITS + 1);

	// datapath widths
	localparam int PROD_BITS = 2 * (SAMPLE_BITS + 1);
	localparam int SUM_BITS  = SAMPLE_BITS + 3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// interpolation modes; bit one alone selects allpass
	localparam logic [MODE_BITS-1:0] MODE_NONE   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_LINEAR = 2'd1;
	localparam int MODE_AP_BIT = 1;

	// request kinds
	localparam logic REQ_READ   = 1'b0;
	localparam logic REQ_INJECT = 1'b1;

	// register indexes
	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_LEN  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COEF_GO,
		ST_COEF,
		ST_ADDR_GO,
		ST_ADDR,
		ST_RDA,
		ST_RDB,
		ST_MUL,
		ST_FIN,
		ST_WR1
	} state_t;

	localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

	// clamp a widened sum to the sample range
	function automatic sample_t sat_sample(input logic signed [SUM_BITS-1:0] v);
		sample_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/fdlt_in_if.sv
`default_nettype none
interface fdlt_in_if;
	import fdlt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [POS_BITS-1:0]   write_pos;
	logic [DELAY_BITS-1:0] delay;
	sample_t               sample;

	modport source (output valid, output req_type, output write_pos, output delay,
		output sample, input ready);
	modport sink (input valid, input req_type, input write_pos, input delay,
		input sample, output ready);
endinterface
`default_nettype wire

// File: design/fdlt_out_if.sv
`default_nettype none
interface fdlt_out_if;
	import fdlt_pkg::*;
	logic    valid;
	logic    ready;
	sample_t tap_value;

	modport source (output valid, output tap_value, input ready);
	modport sink (input valid, input tap_value, output ready);
endinterface
`default_nettype wire

// File: design/fdlt_mod.sv
`default_nettype none
module fdlt_mod (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fdlt_pkg::LEN_BITS-1:0] num,
	input  wire logic [fdlt_pkg::LEN_BITS-1:0] den,
	output logic                               done,
	output logic [fdlt_pkg::ADDR_BITS-1:0]     rem
);
	import fdlt_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [MOD_CNT_BITS-1:0] cnt_q;
	logic [LEN_BITS-1:0]     sh_q;
	logic [LEN_BITS-1:0]     den_q;
	logic [ADDR_BITS-1:0]    rem_q;
	logic [LEN_BITS-1:0]     trial;
	logic                    ge;

	// one restoring step per cycle
	assign trial = {rem_q, sh_q[LEN_BITS-1]};
	assign ge    = (trial >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + MOD_CNT_BITS'(1);
				if (cnt_q == MOD_CNT_BITS'(LEN_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[LEN_BITS-2:0], 1'b0};
			rem_q <= ge ? ADDR_BITS'(trial - den_q) : trial[ADDR_BITS-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// File: design/fdlt_coef.sv
`default_nettype none
module fdlt_coef (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fdlt_pkg::NUM_BITS-1:0] num,
	input  wire logic [fdlt_pkg::DEN_BITS-1:0] den,
	output logic                               done,
	output logic [fdlt_pkg::NUM_BITS-1:0]      quo
);
	import fdlt_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [NUM_BITS-1:0]     sh_q;
	logic [DEN_BITS-1:0]     den_q;
	logic [DEN_BITS-1:0]     rem_q;
	logic [DEN_BITS:0]       trial;
	logic                    ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, sh_q[NUM_BITS-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NUM_BITS-2:0], ge};
			rem_q <= ge ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule
`default_nettype wire

// File: design/fractional_delay_line_tap_core.sv
// Fractional delay line tap.
// Requests arrive on in_ch (valid/ready); a read request yields one tap value
// on out_ch, an inject request adds a sample into the delay memory and yields
// nothing. interp_mode and buffer_length are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce this. One request is worked at
// a time. The cell address comes from a bit-serial modulo unit (13 steps);
// the memory is then read twice, one multiply is registered and the result
// is formed, so a read raises out_ch.valid with in_ch.ready high again in
// the same cycle. An inject in none mode writes its cell in the last step
// and returns to idle; otherwise it then writes the neighbouring cell too.
// An allpass read whose delay differs from the last one first runs the 39-step
// coefficient divider. After reset the delay memory is swept to zero, one
// cell per cycle, over all 4096 cells; in_ch.ready stays low meanwhile and
// configuration writes are taken. The result sits in an output register: a
// new request is taken while it waits, and a finished read holds in its last
// step until out_ch can take the result.
`default_nettype none
module fractional_delay_line_tap_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	fdlt_in_if.sink                                 in_ch,
	fdlt_out_if.source                              out_ch,
	input  wire logic                               cfg_wr_en,
	input  wire logic                               cfg_index,
	input  wire logic [fdlt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import fdlt_pkg::*;

	localparam logic signed [PROD_BITS-1:0] HALF_F  = PROD_BITS'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PROD_BITS-1:0] HALF_AP = PROD_BITS'(1) <<< (SAMPLE_BITS - 2);

	state_t state_q, state_d;

	// configuration
	logic [MODE_BITS-1:0] mode_q;
	logic [LEN_BITS-1:0]  len_q;
	logic [LEN_BITS-1:0]  eff_len;

	// request registers
	logic                  req_q;
	logic [POS_BITS-1:0]   pos_q;
	logic [DELAY_BITS-1:0] delay_q;
	sample_t               smp_q;
	logic [FRAC_BITS-1:0]  f_w;
	logic [INT_BITS-1:0]   ip_w;

	// allpass state
	sample_t               prev_in_q;
	sample_t               prev_out_q;
	logic [DELAY_BITS-1:0] cached_q;
	sample_t               coef_q;
	logic [INT_BITS-1:0]   ap_off_q;
	logic                  neg_q;

	// work registers
	logic [ADDR_BITS-1:0]  a0_q, a1_q;
	sample_t               ca_q, cb_q, w0_q;
	logic signed [PROD_BITS-1:0] prod_q;

	// memory
	sample_t              mem [DEPTH];
	sample_t              rd_q;
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_wa;
	sample_t              mem_wd;
	logic [ADDR_BITS-1:0] mem_ra;
	logic [ADDR_BITS-1:0] clr_q;

	// output register
	logic    out_valid_q;
	sample_t out_data_q;
	logic    out_free;

	// iterative units
	logic                 mod_start, mod_done;
	logic [LEN_BITS-1:0]  mod_num;
	logic [ADDR_BITS-1:0] mod_rem;
	logic                 div_start, div_done;
	logic [NUM_BITS-1:0]  div_num, div_quo;
	logic [DEN_BITS-1:0]  div_den;

	logic                 is_ap, fin_go, recompute;
	logic [INT_BITS-1:0]  offs_w;
	logic [ADDR_BITS:0]   a0_inc;

	// coefficient operands
	logic                 lo_f;
	logic [FRAC_BITS:0]   alpha;
	logic [FRAC_BITS:0]   one_minus;
	logic [FRAC_BITS-1:0] mag;
	sample_t              q_s;

	// datapath
	logic signed [SAMPLE_BITS:0]   mul_a, mul_b;
	logic signed [PROD_BITS-1:0]   prod_w, rnd_f, rnd_a;
	logic signed [SUM_BITS-1:0]    p1_w, lin_sum, ap_sum, inj0_sum, inj1_sum;
	sample_t                       b_eff, result_w, w1_w;

	assign f_w   = delay_q[FRAC_BITS-1:0];
	assign ip_w  = delay_q[DELAY_BITS-1:FRAC_BITS];
	assign is_ap = mode_q[MODE_AP_BIT];

	// length clamp
	always_comb begin
		if (len_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (len_q > LEN_BITS'(DEPTH)) begin
			eff_len = LEN_BITS'(DEPTH);
		end else begin
			eff_len = len_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			len_q  <= LEN_BITS'(DEPTH);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[MODE_BITS-1:0];
				CFG_LEN:  len_q  <= cfg_data[LEN_BITS-1:0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	// coefficient divider operands
	assign lo_f      = ~f_w[FRAC_BITS-1];
	assign alpha     = {lo_f, f_w};
	assign one_minus = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, f_w};
	assign mag       = lo_f ? f_w : one_minus[FRAC_BITS-1:0];
	assign div_den   = {2'b01, {FRAC_BITS{1'b0}}} + {1'b0, alpha};
	assign div_num   = {mag, {(SAMPLE_BITS - 1){1'b0}}}
		+ NUM_BITS'(div_den[DEN_BITS-1:1]);
	assign q_s       = $signed({1'b0, div_quo[SAMPLE_BITS-2:0]});

	fdlt_coef u_coef (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// cell address modulo the length
	assign offs_w  = is_ap && (req_q == REQ_READ) ? ap_off_q : ip_w;
	assign mod_num = {1'b0, pos_q} + {1'b0, offs_w};

	fdlt_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.num   (mod_num),
		.den   (eff_len),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	assign a0_inc = {1'b0, mod_rem} + LEN_BITS'(1);

	// multiplier operand selection
	always_comb begin
		if (req_q == REQ_INJECT) begin
			mul_a = (SAMPLE_BITS + 1)'(smp_q);
			mul_b = $signed((SAMPLE_BITS + 1)'(f_w));
		end else if (is_ap) begin
			mul_a = (SAMPLE_BITS + 1)'(ca_q) - (SAMPLE_BITS + 1)'(prev_out_q);
			mul_b = (SAMPLE_BITS + 1)'(coef_q);
		end else begin
			mul_a = (SAMPLE_BITS + 1)'(rd_q) - (SAMPLE_BITS + 1)'(ca_q);
			mul_b = $signed((SAMPLE_BITS + 1)'(f_w));
		end
	end
	assign prod_w = mul_a * mul_b;

	// rounding and sums
	assign rnd_f    = (prod_q + HALF_F) >>> FRAC_BITS;
	assign rnd_a    = (prod_q + HALF_AP) >>> (SAMPLE_BITS - 1);
	assign p1_w     = (mode_q == MODE_NONE) ? '0 : $signed(rnd_f[SUM_BITS-1:0]);
	assign lin_sum  = SUM_BITS'(ca_q) + $signed(rnd_f[SUM_BITS-1:0]);
	assign ap_sum   = SUM_BITS'(prev_in_q) + $signed(rnd_a[SUM_BITS-1:0]);
	assign inj0_sum = SUM_BITS'(ca_q) + SUM_BITS'(smp_q) - p1_w;
	assign b_eff    = (a1_q == a0_q) ? w0_q : cb_q;
	assign inj1_sum = SUM_BITS'(b_eff) + p1_w;
	assign w1_w     = sat_sample(inj1_sum);

	always_comb begin
		if (mode_q == MODE_NONE) begin
			result_w = ca_q;
		end else if (is_ap) begin
			result_w = sat_sample(ap_sum);
		end else begin
			result_w = sat_sample(lin_sum);
		end
	end

	assign out_free  = !out_valid_q || out_ch.ready;
	assign fin_go    = (req_q == REQ_INJECT) || out_free;
	assign recompute = (in_ch.req_type == REQ_READ) && is_ap && (in_ch.delay != cached_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d     = state_q;
		mod_start   = 1'b0;
		div_start   = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = a0_q;
		mem_wd      = '0;
		mem_ra      = a0_q;
		in_ch.ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == ADDR_BITS'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = recompute ? ST_COEF_GO : ST_ADDR_GO;
			end
			ST_COEF_GO: begin
				div_start = 1'b1;
				state_d   = ST_COEF;
			end
			ST_COEF: begin
				if (div_done) state_d = ST_ADDR_GO;
			end
			ST_ADDR_GO: begin
				mod_start = 1'b1;
				state_d   = ST_ADDR;
			end
			ST_ADDR: begin
				if (mod_done) state_d = ST_RDA;
			end
			ST_RDA: begin
				state_d = ST_RDB;
			end
			ST_RDB: begin
				mem_ra  = a1_q;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (req_q == REQ_INJECT) begin
					mem_we  = 1'b1;
					mem_wd  = sat_sample(inj0_sum);
					state_d = (mode_q == MODE_NONE) ? ST_IDLE : ST_WR1;
				end else if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			ST_WR1: begin
				mem_we  = 1'b1;
				mem_wa  = a1_q;
				mem_wd  = w1_w;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// delay memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + ADDR_BITS'(1);
		end
	end

	// request capture and work registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			req_q   <= in_ch.req_type;
			pos_q   <= in_ch.write_pos;
			delay_q <= in_ch.delay;
			smp_q   <= in_ch.sample;
		end
		if (state_q == ST_ADDR && mod_done) begin
			a0_q <= mod_rem;
			a1_q <= (a0_inc == eff_len) ? '0 : a0_inc[ADDR_BITS-1:0];
		end
		if (state_q == ST_RDB) ca_q <= rd_q;
		if (state_q == ST_MUL) begin
			cb_q   <= rd_q;
			prod_q <= prod_w;
		end
		if (state_q == ST_FIN) w0_q <= sat_sample(inj0_sum);
	end

	// allpass state and coefficient cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_q  <= '0;
			prev_out_q <= '0;
			cached_q   <= '1;
			coef_q     <= '0;
			ap_off_q   <= '0;
			neg_q      <= 1'b0;
		end else begin
			if (state_q == ST_COEF_GO) begin
				cached_q <= delay_q;
				ap_off_q <= lo_f ? ip_w - INT_BITS'(1) : ip_w;
				neg_q    <= lo_f;
			end
			if (state_q == ST_COEF && div_done) begin
				coef_q <= neg_q ? -q_s : q_s;
			end
			if (state_q == ST_FIN && req_q == REQ_READ && is_ap && fin_go) begin
				prev_in_q  <= ca_q;
				prev_out_q <= result_w;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && req_q == REQ_READ && fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && req_q == REQ_READ && fin_go) out_data_q <= result_w;
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.tap_value = out_data_q;

endmodule
`default_nettype wire

// File: tb/fractional_delay_line_tap_core_test.sv
`timescale 1ns / 100ps
module fractional_delay_line_tap_core_test;
	import fdlt_pkg::*;

	typedef struct packed {
		logic                  kind;
		logic [POS_BITS-1:0]   pos;
		logic [DELAY_BITS-1:0] dly;
		sample_t               smp;
	} tap_req_t;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_WAIT  = 150;
	localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	fdlt_in_if  in_ch();
	fdlt_out_if out_ch();

	fractional_delay_line_tap_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// request queue and expected taps
	tap_req_t pending_q[$];
	sample_t  tap_q[$];
	tap_req_t on_bus;
	int errors;
	int mismatches;
	int cycles;
	bit long_hold_req;

	// shadow state of the tap
	sample_t shadow_mem [DEPTH];
	sample_t ap_in, ap_out;
	logic [DELAY_BITS-1:0] ap_cached;
	longint ap_coeff;
	logic [INT_BITS-1:0] ap_offset;
	logic [MODE_BITS-1:0] sh_mode;
	logic [CFG_DATA_BITS-1:0] sh_len;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sample_t clamp24(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		lo = -(longint'(1) << (SAMPLE_BITS - 1));
		if (v > hi) return sample_t'(hi);
		if (v < lo) return sample_t'(lo);
		return sample_t'(v);
	endfunction

	function automatic longint round_sh(longint x, int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic int cell_of(longint pos, longint offs, longint extra);
		longint len;
		len = sh_len;
		if (len == 0) len = 1;
		if (len > DEPTH) len = DEPTH;
		return int'((pos + offs + extra) % len);
	endfunction

	// work out the effect of one accepted request
	task automatic predict_tap(tap_req_t r);
		longint ip, f, s, p1, a, b, x, acc, alpha, num, den, q;
		int a0, a1;
		sample_t res;
		ip = r.dly[DELAY_BITS-1:FRAC_BITS];
		f = r.dly[FRAC_BITS-1:0];
		s = r.smp;
		a0 = cell_of(r.pos, ip, 0);
		a1 = cell_of(r.pos, ip, 1);
		if (r.kind == REQ_INJECT) begin
			if (sh_mode == MODE_NONE) begin
				shadow_mem[a0] = clamp24(longint'(shadow_mem[a0]) + s);
			end else begin
				p1 = round_sh(s * f, FRAC_BITS);
				shadow_mem[a0] = clamp24(longint'(shadow_mem[a0]) + s - p1);
				shadow_mem[a1] = clamp24(longint'(shadow_mem[a1]) + p1);
			end
			return;
		end
		if (sh_mode[MODE_AP_BIT]) begin
			// coefficient only follows a change of delay
			if (r.dly != ap_cached) begin
				ap_cached = r.dly;
				alpha = f;
				if (f < FRAC_ONE / 2) begin
					alpha = f + FRAC_ONE;
					ip = ip - 1;
				end
				ap_offset = ip[INT_BITS-1:0];
				den = FRAC_ONE + alpha;
				num = (alpha <= FRAC_ONE) ? (FRAC_ONE - alpha) : (alpha - FRAC_ONE);
				num = num << (SAMPLE_BITS - 1);
				q = (num + den / 2) / den;
				ap_coeff = (alpha <= FRAC_ONE) ? q : -q;
			end
			x = shadow_mem[cell_of(r.pos, ap_offset, 0)];
			acc = ap_coeff * (x - longint'(ap_out));
			res = clamp24(longint'(ap_in) + round_sh(acc, SAMPLE_BITS - 1));
			ap_in = sample_t'(x);
			ap_out = res;
		end else if (sh_mode == MODE_LINEAR) begin
			a = shadow_mem[a0];
			b = shadow_mem[a1];
			res = clamp24(a + round_sh((b - a) * f, FRAC_BITS));
		end else begin
			res = shadow_mem[a0];
		end
		tap_q.push_back(res);
	endtask

	// request driver, bursts with gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.req_type <= REQ_READ;
			in_ch.write_pos <= '0;
			in_ch.delay <= '0;
			in_ch.sample <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			next_valid = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				predict_tap(on_bus);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0) begin
					on_bus = pending_q.pop_front();
					in_ch.req_type <= on_bus.kind;
					in_ch.write_pos <= on_bus.pos;
					in_ch.delay <= on_bus.dly;
					in_ch.sample <= on_bus.smp;
					next_valid = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end
				end
			end
			in_ch.valid <= next_valid;
		end
	end

	// receiver stall pattern and long hold-off
	int hold_left;
	int pat_left;
	int pat_kind;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left = 0;
			pat_left = 0;
			pat_kind = 0;
		end else begin
			if (pat_left == 0) begin
				pat_left = $urandom_range(16, 128);
				pat_kind = $urandom_range(0, 2);
			end
			pat_left--;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 800;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (pat_kind == 0) begin
				out_ch.ready <= 1'b1;
			end else if (pat_kind == 1) begin
				out_ch.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				out_ch.ready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// tap checker
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (tap_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected tap_value %0d", out_ch.tap_value);
			end else begin
				want = tap_q.pop_front();
				if (out_ch.tap_value !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("tap_value mismatch: expected %0d got %0d",
							want, out_ch.tap_value);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic wait_idle();
		while (!(pending_q.size() == 0 && !in_ch.valid && tap_q.size() == 0))
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_MODE) sh_mode = val[MODE_BITS-1:0];
		else sh_len = val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_req(logic k, int p, logic [DELAY_BITS-1:0] d, sample_t s);
		tap_req_t r;
		r.kind = k;
		r.pos = POS_BITS'(p);
		r.dly = d;
		r.smp = s;
		pending_q.push_back(r);
	endtask

	function automatic logic [FRAC_BITS-1:0] pick_frac();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'hFFFF;
			default: return FRAC_BITS'($urandom);
		endcase
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return sample_t'(24'h7FFFFF);
			1: return sample_t'(24'h800000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_len();
		case ($urandom_range(0, 9))
			0: return 13'd2;
			1: return 13'd0;
			2: return 13'd1;
			3: return 13'd4096;
			4: return CFG_DATA_BITS'($urandom_range(4097, 8191));
			5: return CFG_DATA_BITS'($urandom_range(2, 4096));
			default: return CFG_DATA_BITS'($urandom_range(3, 48));
		endcase
	endfunction

	// stimulus
	initial begin
		logic [DELAY_BITS-1:0] last_dly;
		logic [DELAY_BITS-1:0] d;
		int span;
		int hold_phase;
		errors = 0;
		mismatches = 0;
		cycles = 0;
		long_hold_req = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		for (int i = 0; i < DEPTH; i++) shadow_mem[i] = '0;
		ap_in = '0;
		ap_out = '0;
		ap_cached = '1;
		ap_coeff = 0;
		ap_offset = '0;
		sh_mode = MODE_LINEAR;
		sh_len = 13'd4096;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// allpass first, so the all-ones delay meets the reset cache
		write_reg(CFG_MODE, 13'd2);
		push_req(REQ_INJECT, 0, 28'h0000000, sample_t'(24'h7FFFFF));
		push_req(REQ_INJECT, 4095, 28'hFFFFFFF, sample_t'(24'h400000));
		push_req(REQ_READ, 4095, 28'hFFFFFFF, '0);
		push_req(REQ_READ, 1, 28'h0004000, '0);
		push_req(REQ_READ, 1, 28'h0004000, '0);
		push_req(REQ_READ, 0, 28'h0018000, '0);
		push_req(REQ_READ, 0, 28'h001FFFF, '0);
		wait_idle();
		// none mode, zero length acts as one
		write_reg(CFG_MODE, 13'd0);
		write_reg(CFG_LEN, 13'd0);
		push_req(REQ_INJECT, 4095, 28'hABCDEF1, sample_t'(24'h800000));
		push_req(REQ_INJECT, 7, 28'h0000000, sample_t'(24'h800000));
		push_req(REQ_READ, 123, 28'h1234567, '0);
		wait_idle();
		// linear, length above depth
		write_reg(CFG_MODE, 13'd1);
		write_reg(CFG_LEN, 13'd8191);
		push_req(REQ_INJECT, 4095, 28'h0008000, sample_t'(24'h7FFFFF));
		push_req(REQ_INJECT, 4095, 28'h0008000, sample_t'(24'h7FFFFF));
		push_req(REQ_READ, 4095, 28'h0008000, '0);
		push_req(REQ_READ, 4095, 28'h000FFFF, '0);
		push_req(REQ_READ, 0, 28'h0000000, '0);
		wait_idle();
		// mode three acts as allpass, length two
		write_reg(CFG_MODE, 13'd3);
		write_reg(CFG_LEN, 13'd2);
		push_req(REQ_INJECT, 1, 28'h0007FFF, sample_t'(24'h123456));
		push_req(REQ_READ, 3, 28'h0007FFF, '0);
		push_req(REQ_READ, 2, 28'h0010000, '0);
		push_req(REQ_READ, 2, 28'h0010000, '0);
		wait_idle();

		// random phases
		hold_phase = $urandom_range(1, 8);
		last_dly = '0;
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(CFG_MODE, MODE_BITS'($urandom_range(0, 3)));
			write_reg(CFG_LEN, pick_len());
			if (ph == 4) write_reg(CFG_LEN, 13'd4096);
			span = (sh_len == 0 || sh_len > 64) ? 64 : sh_len;
			for (int n = 0; n < 43; n++) begin
				if ($urandom_range(0, 9) == 0)
					d = DELAY_BITS'($urandom);
				else if (sh_mode[MODE_AP_BIT] && $urandom_range(0, 1) == 0)
					d = last_dly;
				else
					d = {INT_BITS'($urandom_range(0, span)), pick_frac()};
				last_dly = d;
				push_req(logic'($urandom_range(0, 1)), $urandom_range(0, 4095), d,
					pick_sample());
			end
			if (ph == hold_phase) long_hold_req = 1'b1;
			wait_idle();
		end

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
